// ----- src/vsu_pkg.sv -----
// Package with payload types and constants of the vector similarity unit.
package vsu_pkg;

  localparam int unsigned SumW = 48;
  localparam int unsigned ProdW = 96;
  localparam int unsigned RootW = 48;
  localparam int unsigned FracShift = 30;
  localparam int unsigned ElemBits = 16;

  localparam logic [1:0] MetricCos = 2'd0;
  localparam logic [1:0] MetricL2 = 2'd1;
  localparam logic [1:0] MetricDot = 2'd2;

  localparam logic [47:0] SumMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SumMin = 48'h8000_0000_0000;

  typedef struct packed {
    logic signed [ElemBits-1:0] elem_a;
    logic signed [ElemBits-1:0] elem_b;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] score;
    logic zero_norm;
    logic saturated;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_en;
    logic acc_clear;
    logic mul_start;
    logic mul_step;
    logic root_start;
    logic root_step;
    logic div_start;
    logic div_step;
    logic load_result;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_norm;
    logic mag_ge_root;
    logic mul_done;
  } dp_stat_t;

endpackage

// ----- src/vsu_datapath.sv -----
// Datapath: accumulators, product, square root and division units.
`default_nettype none
module vsu_datapath #(
  parameter int unsigned MaxDim   = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vsu_pkg::in_item_t  item_i,
  input  wire logic [1:0]         metric_i,
  input  wire vsu_pkg::dp_cmd_t   cmd_i,
  output vsu_pkg::dp_stat_t       stat_o,
  output vsu_pkg::out_item_t      result_o
);

  localparam int unsigned ElemBits = vsu_pkg::ElemBits;
  localparam int unsigned CntW = $clog2(MaxDim + 1);
  localparam int unsigned SqW  = 2 * ElemBits + 2;
  localparam int unsigned DiffW = ElemBits + 1;

  logic signed [47:0] dot_q, na_q, nb_q, dsq_q;
  logic signed [47:0] dot_d, na_d, nb_d, dsq_d;
  logic sat_q, sat_d;
  logic [CntW-1:0] cnt_q;
  logic signed [ElemBits-1:0] a, b;
  logic signed [ElemBits:0] diff;
  logic signed [SqW-1:0] p_ab, p_aa, p_bb, p_dd;
  logic full, any_sat;
  logic [3:0] ovf;

  assign a    = item_i.elem_a[ElemBits-1:0];
  assign b    = item_i.elem_b[ElemBits-1:0];
  assign diff = DiffW'(a) - DiffW'(b);
  assign p_ab = SqW'(a) * SqW'(b);
  assign p_aa = SqW'(a) * SqW'(a);
  assign p_bb = SqW'(b) * SqW'(b);
  assign p_dd = SqW'(diff) * SqW'(diff);
  assign full = (cnt_q >= CntW'(MaxDim));

  // Saturating add of one product term to a running sum.
  function automatic logic [48:0] sat_add(logic signed [47:0] acc,
                                          logic signed [SqW-1:0] t);
    logic signed [49:0] s;
    s = 50'(acc) + 50'(t);
    if (s > 50'sh7FFF_FFFF_FFFF) return {1'b1, vsu_pkg::SumMax};
    if (s < -50'sh8000_0000_0000) return {1'b1, vsu_pkg::SumMin};
    return {1'b0, s[47:0]};
  endfunction

  always_comb begin
    logic [48:0] r0, r1, r2, r3;
    r0 = sat_add(dot_q, p_ab);
    r1 = sat_add(na_q, p_aa);
    r2 = sat_add(nb_q, p_bb);
    r3 = sat_add(dsq_q, p_dd);
    ovf = {r0[48], r1[48], r2[48], r3[48]};
    dot_d = r0[47:0];
    na_d  = r1[47:0];
    nb_d  = r2[47:0];
    dsq_d = r3[47:0];
  end
  assign any_sat = |ovf;

  // Running sums and pair count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0; na_q <= '0; nb_q <= '0; dsq_q <= '0;
      sat_q <= 1'b0; cnt_q <= '0;
    end else if (cmd_i.acc_clear) begin
      dot_q <= '0; na_q <= '0; nb_q <= '0; dsq_q <= '0;
      sat_q <= 1'b0; cnt_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (full) begin
        sat_q <= 1'b1;
      end else begin
        dot_q <= dot_d; na_q <= na_d; nb_q <= nb_d; dsq_q <= dsq_d;
        sat_q <= sat_q | any_sat;
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Product of the norms, summed from four 24x24 partial products.
  logic [95:0] prod_q;
  logic [1:0]  mstep_q;
  logic        mdone_q;
  logic [23:0] mdig_a, mdig_b;
  logic [47:0] mpart;
  logic [95:0] mterm;
  assign mdig_a = mstep_q[1] ? na_q[47:24] : na_q[23:0];
  assign mdig_b = mstep_q[0] ? nb_q[47:24] : nb_q[23:0];
  assign mpart  = 48'(mdig_a) * 48'(mdig_b);

  // Weight of the partial product by the digits it combines.
  always_comb begin
    unique case (mstep_q)
      2'd0:    mterm = 96'(mpart);
      2'd3:    mterm = {mpart, 48'd0};
      default: mterm = {24'd0, mpart, 24'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstep_q <= '0; mdone_q <= 1'b0; prod_q <= '0;
    end else if (cmd_i.mul_start) begin
      mstep_q <= '0; mdone_q <= 1'b0; prod_q <= '0;
    end else if (cmd_i.mul_step && !mdone_q) begin
      prod_q  <= prod_q + mterm;
      mdone_q <= (mstep_q == 2'd3);
      mstep_q <= mstep_q + 2'd1;
    end
  end

  // Bit-serial integer square root, one result bit per cycle.
  logic [95:0] rem_q;
  logic [95:0] src_q;
  logic [47:0] root_q;
  logic [97:0] trial;
  logic [97:0] rem_sh;
  assign rem_sh = {rem_q, src_q[95:94]};
  assign trial  = {48'd0, root_q, 2'b01};
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      rem_q <= '0; src_q <= prod_q; root_q <= '0;
    end else if (cmd_i.root_step) begin
      src_q <= {src_q[93:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 96'(rem_sh - trial);
        root_q <= {root_q[46:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[95:0];
        root_q <= {root_q[46:0], 1'b0};
      end
    end
  end

  // Restoring division of |dot| * 2^30 by the root, one bit per cycle.
  logic [47:0] mag;
  logic [77:0] dnum_q;
  logic [48:0] drem_q;
  logic [48:0] drem_sh;
  assign mag = dot_q[47] ? 48'(-dot_q) : 48'(dot_q);
  assign drem_sh = {drem_q[47:0], dnum_q[77]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dnum_q <= {mag[47:0], 30'd0};
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (drem_sh >= {1'b0, root_q}) begin
        drem_q <= drem_sh - {1'b0, root_q};
        dnum_q <= {dnum_q[76:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        dnum_q <= {dnum_q[76:0], 1'b0};
      end
    end
  end

  assign stat_o.zero_norm   = (na_q == '0) || (nb_q == '0);
  assign stat_o.mag_ge_root = (mag >= root_q);
  assign stat_o.mul_done    = mdone_q;

  // Result register.
  logic [47:0] q_mag;
  logic signed [47:0] score;
  assign q_mag = stat_o.mag_ge_root ? 48'(1) << vsu_pkg::FracShift : dnum_q[47:0];
  always_comb begin
    unique case (metric_i)
      vsu_pkg::MetricCos: begin
        if (stat_o.zero_norm) score = '0;
        else score = dot_q[47] ? -$signed(q_mag) : $signed(q_mag);
      end
      vsu_pkg::MetricL2: score = dsq_q;
      default: score = dot_q;
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      result_o.score     <= score;
      result_o.zero_norm <= (metric_i == vsu_pkg::MetricCos) && stat_o.zero_norm;
      result_o.saturated <= sat_q;
    end
  end

endmodule
`default_nettype wire

// ----- src/vsu_ctrl.sv -----
// Controller state machine sequencing accumulate, norm product, root and divide.
`default_nettype none
module vsu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              last_i,
  input  wire logic [1:0]        metric_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output vsu_pkg::dp_cmd_t       cmd_o,
  input  wire vsu_pkg::dp_stat_t stat_i
);

  localparam logic [2:0] StAcc  = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StRoot = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StLoad = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic       ovld_q, ovld_d;
  logic       take;

  assign in_ready_o  = (state_q == StAcc) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign take        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      StAcc: begin
        cmd_o.acc_en = take;
        if (take && last_i) begin
          state_d = StMul;
          cmd_o.mul_start = 1'b1;
        end
      end
      StMul: begin
        if (metric_i != vsu_pkg::MetricCos || stat_i.zero_norm) begin
          state_d = StLoad;
        end else if (stat_i.mul_done) begin
          state_d = StRoot;
          cmd_o.root_start = 1'b1;
          cnt_d = 7'd0;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd47) begin
          state_d = StDiv;
          cnt_d = 7'd0;
        end
      end
      StDiv: begin
        if (cnt_q == 7'd0) begin
          cmd_o.div_start = 1'b1;
          cnt_d = 7'd1;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d = cnt_q + 7'd1;
          if (cnt_q == 7'd78 || stat_i.mag_ge_root) state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load_result = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        ovld_d = 1'b1;
        cmd_o.acc_clear = 1'b1;
        state_d = StAcc;
      end
      default: state_d = StAcc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAcc;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/vector_similarity_unit.sv -----
// Top level of the vector similarity unit.
//
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid/in_ready    | elem_a, elem_b, last
//  out      | output    | out_valid/out_ready  | score, zero_norm, saturated
//  config   | input     | APB psel/penable     | metric at address 0
//
// Each element pair is added to the running sums in the multiply-accumulate
// stage. After the last pair, inner product and distance go straight to the
// result register; cosine first adds a norm product, a square root and a division.
// Input is held off while a result is computed or waits to be taken.
// Reset clears all sums and the metric register at once.
`default_nettype none
module vector_similarity_unit #(
  parameter int unsigned MaxDim   = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire vsu_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output vsu_pkg::out_item_t       out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [1:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [1:0] metric_q;
  vsu_pkg::dp_cmd_t  cmd;
  vsu_pkg::dp_stat_t stat;

  // Metric register.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= vsu_pkg::MetricCos;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      metric_q <= pwdata[1:0];
    end
  end
  assign prdata = (paddr == 2'd0) ? {30'd0, metric_q} : '0;

  vsu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .last_i(in_data_i.last), .metric_i(metric_q),
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .stat_i(stat)
  );

  vsu_datapath #(.MaxDim(MaxDim)) u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .metric_i(metric_q),
    .cmd_i(cmd), .stat_o(stat), .result_o(out_data_o)
  );

endmodule
`default_nettype wire

// ----- src/vsu_checker.sv -----
// Port-level checker for the vector similarity unit, with its bind.
`default_nettype none
module vsu_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire vsu_pkg::out_item_t out_data_o
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_zero_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_norm |-> out_data_o.score == '0)
    else $error("zero norm with nonzero score");
  a_no_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o) else $error("result repeated");
endmodule

bind vector_similarity_unit vsu_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire
